// File: design/nec_ir_edge_decoder_top_defines.svh
// Assertion macros used by the back end of the NEC infrared edge decoder.
`ifndef NEC_IR_EDGE_DECODER_TOP_DEFINES_SVH
`define NEC_IR_EDGE_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NIRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NIRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/nird_pkg.sv
// Types and constants shared by the NEC infrared edge decoder modules.
`timescale 1ns / 1ps

package nird_pkg;

    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;
    localparam int TIMEOUT_W = 20;
    localparam int MSG_W     = 32;
    localparam int BITS_W    = 6;
    localparam int STATUS_W  = 3;
    localparam int EDGE_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    // Depths of the command and result queues; powers of two.
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_GAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_GAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLACK       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd5;

    // Values of the registers after reset.
    localparam logic [DUR_W-1:0]     RST_START_PULSE = 16'd9000;
    localparam logic [DUR_W-1:0]     RST_START_SPACE = 16'd4500;
    localparam logic [DUR_W-1:0]     RST_ONE_GAP     = 16'd2250;
    localparam logic [DUR_W-1:0]     RST_ZERO_GAP    = 16'd1125;
    localparam logic [DUR_W-1:0]     RST_SLACK       = 16'd300;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT     = 20'd10000;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DECODED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_START = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_TIMING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic              operation;
        logic              edge_fall;
        logic              edge_rise;
        logic [TIME_W-1:0] time_us;
    } nird_in_t;

    typedef struct packed {
        logic [MSG_W-1:0]    message;
        logic [BITS_W-1:0]   bit_total;
        logic [STATUS_W-1:0] status;
    } nird_out_t;

    typedef enum logic {
        CMD_EDGE,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              fall;
        logic              rise;
        logic [TIME_W-1:0] time_us;
    } cmd_t;

    // Inclusive acceptance window for a duration.
    typedef struct packed {
        logic [DUR_W-1:0] lo;
        logic [DUR_W:0]   hi;
    } win_t;

    typedef struct packed {
        win_t                 pulse;
        win_t                 space;
        win_t                 one;
        win_t                 zero;
        logic [TIMEOUT_W-1:0] timeout;
    } bounds_t;

endpackage

// File: design/nird_fifo.sv
// Small first-in first-out queue with full and empty flags.
`timescale 1ns / 1ps

module nird_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      rd_ptr_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                     (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// File: design/nird_front.sv
// Front end: configuration registers, window bounds and input classification.
`timescale 1ns / 1ps

module nird_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  nird_pkg::nird_in_t                  item,
    input  logic                                cmd_full,
    output logic                                cmd_push,
    output nird_pkg::cmd_t                      cmd,
    input  logic                                cfg_we,
    input  logic [nird_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nird_pkg::CFG_DAT_W-1:0]      cfg_data,
    output nird_pkg::bounds_t                   bounds
);

    import nird_pkg::*;

    logic [DUR_W-1:0]     start_pulse_reg;
    logic [DUR_W-1:0]     start_space_reg;
    logic [DUR_W-1:0]     one_gap_reg;
    logic [DUR_W-1:0]     zero_gap_reg;
    logic [DUR_W-1:0]     slack_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    bounds_t              bounds_reg;
    bounds_t              bounds_next;

    // The lower bound saturates at zero when the slack exceeds the nominal value.
    function automatic win_t win_of(input logic [DUR_W-1:0] nom,
                                    input logic [DUR_W-1:0] slack);
        win_t w;
        w.lo = (nom >= slack) ? (nom - slack) : '0;
        w.hi = {1'b0, nom} + {1'b0, slack};
        return w;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pulse_reg <= RST_START_PULSE;
            start_space_reg <= RST_START_SPACE;
            one_gap_reg     <= RST_ONE_GAP;
            zero_gap_reg    <= RST_ZERO_GAP;
            slack_reg       <= RST_SLACK;
            timeout_reg     <= RST_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_PULSE: start_pulse_reg <= cfg_data[DUR_W-1:0];
                REG_START_SPACE: start_space_reg <= cfg_data[DUR_W-1:0];
                REG_ONE_GAP:     one_gap_reg     <= cfg_data[DUR_W-1:0];
                REG_ZERO_GAP:    zero_gap_reg    <= cfg_data[DUR_W-1:0];
                REG_SLACK:       slack_reg       <= cfg_data[DUR_W-1:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data[TIMEOUT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        bounds_next.pulse   = win_of(start_pulse_reg, slack_reg);
        bounds_next.space   = win_of(start_space_reg, slack_reg);
        bounds_next.one     = win_of(one_gap_reg, slack_reg);
        bounds_next.zero    = win_of(zero_gap_reg, slack_reg);
        bounds_next.timeout = timeout_reg;
    end

    // Bounds follow the registers in the cycle after a write, which is still before an item
    // transferred after a configuration write can reach the back end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.pulse   <= win_of(RST_START_PULSE, RST_SLACK);
            bounds_reg.space   <= win_of(RST_START_SPACE, RST_SLACK);
            bounds_reg.one     <= win_of(RST_ONE_GAP, RST_SLACK);
            bounds_reg.zero    <= win_of(RST_ZERO_GAP, RST_SLACK);
            bounds_reg.timeout <= RST_TIMEOUT;
        end
        else
        begin
            bounds_reg <= bounds_next;
        end
    end

    assign bounds = bounds_reg;

    // Ticks ignore the edge flags, so they are dropped here.
    always_comb
    begin
        cmd_push     = push && !cmd_full;
        cmd.kind     = item.operation ? CMD_TICK : CMD_EDGE;
        cmd.fall     = item.edge_fall && !item.operation;
        cmd.rise     = item.edge_rise && !item.operation;
        cmd.time_us  = item.time_us;
    end

endmodule

// File: design/nird_back.sv
// Back end: frame state, incremental bit decoding and result generation.
`timescale 1ns / 1ps
`include "nec_ir_edge_decoder_top_defines.svh"

module nird_back #(
    parameter int BUFFER_DEPTH = 64,
    parameter int MESSAGE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nird_pkg::cmd_t     cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    input  nird_pkg::bounds_t  bounds,
    input  logic               res_full,
    output logic               res_push,
    output nird_pkg::nird_out_t res
);

    import nird_pkg::*;

    logic [EDGE_W-1:0]       edge_total_reg,  edge_total_next;
    logic                    start_ok_reg,    start_ok_next;
    logic [TIME_W-1:0]       last_fall_reg,   last_fall_next;
    logic [TIME_W-1:0]       last_edge_reg,   last_edge_next;
    logic [MESSAGE_BITS-1:0] shift_bits_reg,  shift_bits_next;
    logic [BITS_W-1:0]       bits_taken_reg,  bits_taken_next;
    logic                    timing_bad_reg,  timing_bad_next;

    logic [TIME_W-1:0] since_edge;
    logic [TIME_W-1:0] since_fall;
    logic              in_pulse;
    logic              in_space;
    logic              in_one;
    logic              in_zero;

    function automatic logic in_win(input logic [TIME_W-1:0] d, input win_t w);
        return (d >= TIME_W'(w.lo)) && (d <= TIME_W'(w.hi));
    endfunction

    assign since_edge = cmd.time_us - last_edge_reg;
    assign since_fall = cmd.time_us - last_fall_reg;
    assign in_pulse   = in_win(since_edge, bounds.pulse);
    assign in_space   = in_win(since_edge, bounds.space);
    assign in_one     = in_win(since_fall, bounds.one);
    assign in_zero    = in_win(since_fall, bounds.zero);

    always_comb
    begin
        edge_total_next = edge_total_reg;
        start_ok_next   = start_ok_reg;
        last_fall_next  = last_fall_reg;
        last_edge_next  = last_edge_reg;
        shift_bits_next = shift_bits_reg;
        bits_taken_next = bits_taken_reg;
        timing_bad_next = timing_bad_reg;
        res_push        = 1'b0;
        res             = '0;
        cmd_pop         = !cmd_empty && !res_full;

        if (cmd_pop)
        begin
            if (cmd.kind == CMD_TICK)
            begin
                if ((edge_total_reg != '0) && (since_edge > TIME_W'(bounds.timeout)))
                begin
                    res_push = 1'b1;
                    priority if (edge_total_reg < EDGE_W'(3))
                    begin
                        res.status = ST_TOO_FEW;
                    end
                    else if (!start_ok_reg)
                    begin
                        res.status = ST_BAD_START;
                    end
                    else if (timing_bad_reg)
                    begin
                        res.status = ST_BAD_TIMING;
                    end
                    else
                    begin
                        res.status    = ST_DECODED;
                        res.message   = MSG_W'(shift_bits_reg);
                        res.bit_total = bits_taken_reg;
                    end
                    edge_total_next = '0;
                    start_ok_next   = 1'b0;
                    last_fall_next  = '0;
                    shift_bits_next = '0;
                    bits_taken_next = '0;
                    timing_bad_next = 1'b0;
                end
            end
            else if (edge_total_reg >= EDGE_W'(BUFFER_DEPTH))
            begin
                // A full frame buffer drops the edge and restarts the frame.
                res_push        = 1'b1;
                res.status      = ST_OVERFLOW;
                edge_total_next = '0;
                start_ok_next   = 1'b0;
                last_fall_next  = '0;
                shift_bits_next = '0;
                bits_taken_next = '0;
                timing_bad_next = 1'b0;
            end
            else
            begin
                priority if (edge_total_reg == EDGE_W'(0))
                begin
                    start_ok_next = cmd.fall;
                end
                else if (edge_total_reg == EDGE_W'(1))
                begin
                    start_ok_next = start_ok_reg && cmd.rise && in_pulse;
                end
                else if (edge_total_reg == EDGE_W'(2))
                begin
                    start_ok_next  = start_ok_reg && cmd.fall && in_space;
                    last_fall_next = cmd.time_us;
                end
                else if (!timing_bad_reg && (bits_taken_reg < BITS_W'(MESSAGE_BITS)) &&
                         !cmd.rise)
                begin
                    // Any data edge without the rising flag counts as a fall.
                    last_fall_next = cmd.time_us;
                    if (in_one)
                    begin
                        shift_bits_next = (shift_bits_reg << 1) | MESSAGE_BITS'(1);
                        bits_taken_next = bits_taken_reg + 1'b1;
                    end
                    else if (in_zero)
                    begin
                        shift_bits_next = shift_bits_reg << 1;
                        bits_taken_next = bits_taken_reg + 1'b1;
                    end
                    else
                    begin
                        timing_bad_next = 1'b1;
                    end
                end
                last_edge_next  = cmd.time_us;
                edge_total_next = edge_total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
            start_ok_reg   <= 1'b0;
            last_fall_reg  <= '0;
            last_edge_reg  <= '0;
            shift_bits_reg <= '0;
            bits_taken_reg <= '0;
            timing_bad_reg <= 1'b0;
        end
        else
        begin
            edge_total_reg <= edge_total_next;
            start_ok_reg   <= start_ok_next;
            last_fall_reg  <= last_fall_next;
            last_edge_reg  <= last_edge_next;
            shift_bits_reg <= shift_bits_next;
            bits_taken_reg <= bits_taken_next;
            timing_bad_reg <= timing_bad_next;
        end
    end

    `NIRD_ASSERT_NOW(a_result_needs_command, clk, rst_n, res_push, cmd_pop, "result without command")
    `NIRD_ASSERT_NOW(a_bits_bounded, clk, rst_n, 1'b1, bits_taken_reg <= BITS_W'(MESSAGE_BITS), "bit count beyond message width")
    `NIRD_ASSERT_NOW(a_edges_bounded, clk, rst_n, 1'b1, edge_total_reg <= EDGE_W'(BUFFER_DEPTH), "edge count beyond buffer depth")
    `NIRD_ASSERT_NOW(a_failed_frame_empty, clk, rst_n, res_push && (res.status != ST_DECODED), (res.message == '0) && (res.bit_total == '0), "failed frame carries data")
    `NIRD_ASSERT_NEXT(a_result_clears_frame, clk, rst_n, res_push, (edge_total_reg == '0) && (bits_taken_reg == '0) && !timing_bad_reg, "frame not cleared after result")

endmodule

// File: design/nec_ir_edge_decoder_top.sv
// NEC infrared edge decoder: a result is pushed in the same cycle as its command is popped.
// Throughput is one item per cycle while neither queue is full; the frame update is registered.
// Command and result queues of four entries each let the input and output sides stall apart.
// Reset is asynchronous and active low; it empties both queues, clears the frame and
// restores the configuration registers to their default timings.
`timescale 1ns / 1ps

module nec_ir_edge_decoder_top #(
    parameter int BUFFER_DEPTH = 64,
    parameter int MESSAGE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  nird_pkg::nird_in_t             item,
    output logic                           empty,
    input  logic                           pop,
    output nird_pkg::nird_out_t            result,
    input  logic                           cfg_we,
    input  logic [nird_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nird_pkg::CFG_DAT_W-1:0] cfg_data
);

    import nird_pkg::*;

    logic      cmd_push;
    logic      cmd_full;
    logic      cmd_empty;
    logic      cmd_pop;
    cmd_t      cmd_in;
    cmd_t      cmd_out;
    bounds_t   bounds;
    logic      res_push;
    logic      res_full;
    nird_out_t res_in;

    assign full = cmd_full;

    nird_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bounds    (bounds)
    );

    nird_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    nird_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MESSAGE_BITS (MESSAGE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .bounds    (bounds),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    nird_fifo #(
        .WIDTH ($bits(nird_out_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// File: dv/nec_ir_edge_decoder_top_tb.sv
// Self-checking testbench for the NEC infrared edge decoder: predicts frame reports and checks them.
`timescale 1ns / 1ps

module nec_ir_edge_decoder_top_tb;

    import nird_pkg::*;

    localparam int FRAME_EDGES    = 64;
    localparam int DATA_BITS      = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_TARGET    = 500;
    localparam int REPORT_TARGET  = 48;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    nird_in_t             item      = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    nird_out_t            result;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    nec_ir_edge_decoder_top #(
        .BUFFER_DEPTH(FRAME_EDGES),
        .MESSAGE_BITS(DATA_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Timing registers as the decoder should currently hold them.
    logic [DUR_W-1:0]     cfg_pulse;
    logic [DUR_W-1:0]     cfg_space;
    logic [DUR_W-1:0]     cfg_one;
    logic [DUR_W-1:0]     cfg_zero;
    logic [DUR_W-1:0]     cfg_slack;
    logic [TIMEOUT_W-1:0] cfg_timeout;

    // Frame state of the predictor.
    logic [EDGE_W-1:0]  edge_cnt;
    logic [1:0]         head_flags [3];
    logic [TIME_W-1:0]  head_times [2];
    logic [TIME_W-1:0]  fall_ref_us;
    logic [TIME_W-1:0]  edge_ref_us;
    logic [MSG_W-1:0]   bits_sr;
    logic [BITS_W-1:0]  bit_cnt;
    logic               timing_err;
    logic               start_ok;

    nird_in_t  item_backlog [$];
    nird_out_t frame_reports_q [$];

    int  items_queued      = 0;
    int  items_accepted    = 0;
    int  reports_predicted = 0;
    int  reports_checked   = 0;
    int  error_count       = 0;
    int  timing_sets       = 1;
    int  status_seen [5]   = '{default: 0};
    int  send_wait         = 0;
    int  recv_wait         = 0;
    int  hold_reqs         = 0;
    int  holds_done        = 0;
    int  hold_count        = 0;
    int  idle_cycles       = 0;
    bit  quiet_send        = 1'b0;
    bit  quiet_recv        = 1'b0;

    logic [TIME_W-1:0] clock_us;
    logic [TIME_W-1:0] gen_last_edge;

    function automatic bit coin();
        return bit'($urandom_range(0, 1));
    endfunction

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Inclusive window test, done wide enough that nominal plus slack cannot wrap.
    function automatic bit in_window(logic [TIME_W-1:0] d, logic [DUR_W-1:0] nominal);
        logic [33:0] dw;
        logic [33:0] nw;
        logic [33:0] sw;
        dw = d;
        nw = nominal;
        sw = cfg_slack;
        return (dw + sw >= nw) && (dw <= nw + sw);
    endfunction

    task automatic frame_clear();
        edge_cnt    = '0;
        head_flags  = '{default: 2'b00};
        head_times  = '{default: '0};
        fall_ref_us = '0;
        bits_sr     = '0;
        bit_cnt     = '0;
        timing_err  = 1'b0;
        start_ok    = 1'b0;
    endtask

    task automatic nec_decode_step(nird_in_t it);
        nird_out_t         rep;
        logic [TIME_W-1:0] gap;
        rep = '0;
        if (it.operation == CMD_TICK)
        begin
            if (edge_cnt != 0 && (it.time_us - edge_ref_us) > {12'd0, cfg_timeout})
            begin
                if (edge_cnt < 3)
                    rep.status = ST_TOO_FEW;
                else if (!start_ok)
                    rep.status = ST_BAD_START;
                else if (timing_err)
                    rep.status = ST_BAD_TIMING;
                else
                begin
                    rep.status    = ST_DECODED;
                    rep.message   = bits_sr;
                    rep.bit_total = bit_cnt;
                end
                frame_reports_q.push_back(rep);
                reports_predicted++;
                frame_clear();
            end
        end
        else if (edge_cnt >= FRAME_EDGES)
        begin
            // The edge is dropped; its time is not recorded.
            frame_clear();
            rep.status = ST_OVERFLOW;
            frame_reports_q.push_back(rep);
            reports_predicted++;
        end
        else
        begin
            if (edge_cnt < 3)
            begin
                head_flags[edge_cnt] = {it.edge_rise, it.edge_fall};
                if (edge_cnt < 2)
                    head_times[edge_cnt] = it.time_us;
                else
                begin
                    fall_ref_us = it.time_us;
                    start_ok = head_flags[0][0] && head_flags[1][1] && head_flags[2][0] &&
                               in_window(head_times[1] - head_times[0], cfg_pulse) &&
                               in_window(it.time_us - head_times[1], cfg_space);
                end
            end
            else if (!timing_err && bit_cnt < DATA_BITS && !it.edge_rise)
            begin
                gap         = it.time_us - fall_ref_us;
                fall_ref_us = it.time_us;
                if (in_window(gap, cfg_one))
                begin
                    bits_sr = {bits_sr[MSG_W-2:0], 1'b1};
                    bit_cnt = bit_cnt + 1'b1;
                end
                else if (in_window(gap, cfg_zero))
                begin
                    bits_sr = {bits_sr[MSG_W-2:0], 1'b0};
                    bit_cnt = bit_cnt + 1'b1;
                end
                else
                    timing_err = 1'b1;
            end
            edge_ref_us = it.time_us;
            edge_cnt    = edge_cnt + 1'b1;
        end
    endtask

    task automatic check_report(nird_out_t got);
        nird_out_t want;
        if (frame_reports_q.size() == 0)
        begin
            if (error_count < 10)
                $display("unexpected result: msg=%h bits=%0d status=%0d",
                         got.message, got.bit_total, got.status);
            error_count++;
        end
        else
        begin
            want = frame_reports_q.pop_front();
            reports_checked++;
            if (want.status <= ST_OVERFLOW)
                status_seen[want.status]++;
            if (got.message !== want.message || got.bit_total !== want.bit_total ||
                got.status !== want.status)
            begin
                if (error_count < 10)
                    $display("mismatch on report %0d: expected msg=%h bits=%0d status=%0d, got msg=%h bits=%0d status=%0d",
                             reports_checked, want.message, want.bit_total, want.status,
                             got.message, got.bit_total, got.status);
                error_count++;
            end
        end
    endtask

    // Sender: the prediction is made at the edge where the transfer happens.
    always @(posedge clk or negedge rst_n)
    begin : sender
        if (!rst_n)
        begin
            push      <= 1'b0;
            send_wait <= 0;
        end
        else if (!(push && full))
        begin
            if (push)
            begin
                nec_decode_step(item);
                items_accepted++;
            end
            if (send_wait != 0)
            begin
                push      <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (item_backlog.size() != 0)
            begin
                item      <= item_backlog.pop_front();
                push      <= 1'b1;
                send_wait <= draw_gap(quiet_send);
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        bit taken;
        int gap_draw;
        if (!rst_n)
        begin
            pop       <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            taken = pop && !empty;
            if (taken)
                check_report(result);
            if (holds_done < hold_reqs)
            begin
                // A long hold-off lets both internal queues fill up.
                pop <= 1'b0;
                if (hold_count == HOLD_CYCLES - 1)
                begin
                    hold_count <= 0;
                    holds_done <= holds_done + 1;
                end
                else
                    hold_count <= hold_count + 1;
            end
            else if (taken)
            begin
                gap_draw = draw_gap(quiet_recv);
                recv_wait <= gap_draw;
                pop       <= (gap_draw == 0);
            end
            else if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                pop       <= (recv_wait == 1);
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no transfer for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(cmd_kind_t kind, logic fall, logic rise, logic [TIME_W-1:0] t);
        nird_in_t it;
        while (item_backlog.size() >= 4)
            @(negedge clk);
        it.operation = kind;
        it.edge_fall = fall;
        it.edge_rise = rise;
        it.time_us   = t;
        item_backlog.push_back(it);
        items_queued++;
        if (kind == CMD_EDGE)
            gen_last_edge = t;
    endtask

    // Tick past the timeout by an optional extra amount, then move the running clock on for the next frame.
    task automatic send_tick(int unsigned extra);
        logic [TIME_W-1:0] t;
        t = gen_last_edge + cfg_timeout + 1 + extra;
        add_item(CMD_TICK, coin(), coin(), t);
        clock_us = t + $urandom_range(1, 3000);
    endtask

    function automatic logic [TIME_W-1:0] pick_in(logic [DUR_W-1:0] nominal);
        int unsigned lo;
        int unsigned hi;
        lo = (nominal > cfg_slack) ? nominal - cfg_slack : 0;
        hi = nominal + cfg_slack;
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return lo + $urandom_range(0, hi - lo);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_out(logic [DUR_W-1:0] nominal);
        if (nominal > cfg_slack && coin())
            return $urandom_range(0, nominal - cfg_slack - 1);
        return nominal + cfg_slack + 1 + $urandom_range(0, 1000);
    endfunction

    // One frame: mostly well formed, some with a broken start, bad timing, too few edges or long data runs.
    task automatic send_frame();
        int                flavour;
        int                nbits;
        int                bad_at;
        int                fault;
        int                i;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] d;
        logic [1:0]        head [3];
        quiet_send = ($urandom_range(0, 5) == 0);
        quiet_recv = ($urandom_range(0, 5) == 0);
        flavour    = $urandom_range(0, 99);
        nbits      = (flavour < 8) ? $urandom_range(28, 66) : $urandom_range(0, 12);
        bad_at     = (flavour >= 15 && flavour < 25) ? $urandom_range(0, nbits) : -1;
        fault      = (flavour >= 8 && flavour < 15) ? $urandom_range(0, 2) : -1;
        head[0] = 2'b01;
        head[1] = 2'b10;
        head[2] = 2'b01;
        for (i = 0; i < 3; i++)
            if ($urandom_range(0, 3) == 0)
                head[i] = 2'b11;
        if (fault == 2)
        begin
            i = $urandom_range(0, 2);
            head[i] = coin() ? 2'b00 : ((i == 1) ? 2'b01 : 2'b10);
        end
        t = clock_us;
        add_item(CMD_EDGE, head[0][0], head[0][1], t);
        if (flavour >= 25 && flavour < 30)
        begin
            if (coin())
                add_item(CMD_EDGE, head[1][0], head[1][1], t + pick_in(cfg_pulse));
        end
        else
        begin
            t = t + ((fault == 0) ? pick_out(cfg_pulse) : pick_in(cfg_pulse));
            add_item(CMD_EDGE, head[1][0], head[1][1], t);
            t = t + ((fault == 1) ? pick_out(cfg_space) : pick_in(cfg_space));
            add_item(CMD_EDGE, head[2][0], head[2][1], t);
            for (i = 0; i < nbits; i++)
            begin
                if (i == bad_at)
                    d = ((cfg_one > cfg_zero) ? cfg_one : cfg_zero) + cfg_slack + 1 +
                        $urandom_range(0, 500);
                else
                    d = pick_in(coin() ? cfg_one : cfg_zero);
                case ($urandom_range(0, 3))
                    0, 1: add_item(CMD_EDGE, 1'b0, 1'b1, t + d / 2);
                    2:    add_item(CMD_EDGE, 1'b1, 1'b1, t + d / 2);
                    default: ;
                endcase
                t = t + d;
                // An edge with neither flag still counts as a fall among data edges.
                add_item(CMD_EDGE, ($urandom_range(0, 7) != 0), 1'b0, t);
            end
        end
        if ($urandom_range(0, 3) == 0)
            add_item(CMD_TICK, coin(), coin(), gen_last_edge + $urandom_range(0, cfg_timeout));
        send_tick(coin() ? 0 : $urandom_range(0, 2000));
    endtask

    task automatic run_random(int count);
        int first;
        first = items_queued;
        while (items_queued - first < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    add_item(cmd_kind_t'(coin()), coin(), coin(), $urandom());
                send_tick(0);
            end
            send_frame();
        end
    endtask

    // The receiver stalls while short frames keep arriving, so the input side backs up.
    task automatic flood_while_stalled();
        hold_reqs++;
        quiet_send = 1'b1;
        repeat (10)
        begin
            add_item(CMD_EDGE, 1'b1, 1'b0, clock_us);
            send_tick(0);
        end
        quiet_send = 1'b0;
    endtask

    task automatic settle();
        while (item_backlog.size() != 0 || push || frame_reports_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_PULSE: cfg_pulse   = val[DUR_W-1:0];
            REG_START_SPACE: cfg_space   = val[DUR_W-1:0];
            REG_ONE_GAP:     cfg_one     = val[DUR_W-1:0];
            REG_ZERO_GAP:    cfg_zero    = val[DUR_W-1:0];
            REG_SLACK:       cfg_slack   = val[DUR_W-1:0];
            REG_TIMEOUT:     cfg_timeout = val;
            default: ;
        endcase
    endtask

    task automatic program_timing(int unsigned pulse, int unsigned space, int unsigned one,
                                  int unsigned zero, int unsigned slack, int unsigned tmo);
        settle();
        set_reg(REG_START_PULSE, CFG_DAT_W'(pulse));
        set_reg(REG_START_SPACE, CFG_DAT_W'(space));
        set_reg(REG_ONE_GAP, CFG_DAT_W'(one));
        set_reg(REG_ZERO_GAP, CFG_DAT_W'(zero));
        set_reg(REG_SLACK, CFG_DAT_W'(slack));
        set_reg(REG_TIMEOUT, CFG_DAT_W'(tmo));
        @(negedge clk);
        timing_sets++;
        clock_us = $urandom();
    endtask

    initial
    begin : stimulus
        logic [TIME_W-1:0] t;
        cfg_pulse   = RST_START_PULSE;
        cfg_space   = RST_START_SPACE;
        cfg_one     = RST_ONE_GAP;
        cfg_zero    = RST_ZERO_GAP;
        cfg_slack   = RST_SLACK;
        cfg_timeout = RST_TIMEOUT;
        frame_clear();
        edge_ref_us   = '0;
        gen_last_edge = '0;
        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames under the reset timings, starting just below the time wrap.
        t = 32'hFFFF_D000;
        add_item(CMD_TICK, 1'b1, 1'b1, t);
        add_item(CMD_EDGE, 1'b1, 1'b0, t);
        t = t + 9300;
        add_item(CMD_EDGE, 1'b0, 1'b1, t);
        t = t + 4200;
        add_item(CMD_EDGE, 1'b1, 1'b0, t);
        t = t + 2250;
        add_item(CMD_EDGE, 1'b1, 1'b0, t);
        add_item(CMD_EDGE, 1'b0, 1'b1, t + 500);
        add_item(CMD_EDGE, 1'b1, 1'b1, t + 800);
        t = t + 825;
        add_item(CMD_EDGE, 1'b1, 1'b0, t);
        t = t + 2550;
        add_item(CMD_EDGE, 1'b0, 1'b0, t);
        add_item(CMD_TICK, 1'b1, 1'b0, t + 5000);
        add_item(CMD_TICK, 1'b0, 1'b1, t + 10000);
        add_item(CMD_TICK, 1'b0, 1'b0, t + 10001);
        // Too few edges.
        t = t + 50000;
        add_item(CMD_EDGE, 1'b1, 1'b0, t);
        add_item(CMD_EDGE, 1'b0, 1'b1, t + 9000);
        add_item(CMD_TICK, 1'b0, 1'b0, t + 19001);
        // Both flags pass on the edges that open and close the start pulse; no flag fails the edge ending the space.
        t = t + 60000;
        add_item(CMD_EDGE, 1'b1, 1'b1, t);
        add_item(CMD_EDGE, 1'b1, 1'b1, t + 9000);
        add_item(CMD_EDGE, 1'b0, 1'b0, t + 13500);
        add_item(CMD_TICK, 1'b0, 1'b0, t + 23501);
        // A gap outside both windows latches a timing error.
        t = t + 60000;
        add_item(CMD_EDGE, 1'b1, 1'b0, t);
        add_item(CMD_EDGE, 1'b0, 1'b1, t + 9000);
        add_item(CMD_EDGE, 1'b1, 1'b0, t + 13500);
        add_item(CMD_EDGE, 1'b1, 1'b0, t + 14625);
        add_item(CMD_EDGE, 1'b1, 1'b0, t + 16225);
        add_item(CMD_EDGE, 1'b1, 1'b0, t + 18475);
        add_item(CMD_TICK, 1'b0, 1'b0, t + 28476);
        clock_us = t + 40000;

        run_random(60);
        flood_while_stalled();
        settle();
        run_random(60);

        program_timing(0, 0, 0, 0, 0, 0);
        run_random(70);
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1000000);
        run_random(70);
        program_timing($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(200, 20000), $urandom_range(200, 20000),
                       $urandom_range(0, 2000), $urandom_range(0, 1000000));
        run_random(40);
        flood_while_stalled();
        run_random(40);
        program_timing(RST_START_PULSE, RST_START_SPACE, RST_ONE_GAP, RST_ZERO_GAP,
                       $urandom_range(50, 400), $urandom_range(5000, 20000));
        while (items_queued < ITEM_TARGET || reports_predicted < REPORT_TARGET)
            run_random(20);

        settle();
        $display("Covered %0d item transfers across %0d timing settings, %0d reports checked.",
                 items_accepted, timing_sets, reports_checked);
        $display("Reports: %0d decoded, %0d too few, %0d bad start, %0d bad timing, %0d overflow.",
                 status_seen[ST_DECODED], status_seen[ST_TOO_FEW], status_seen[ST_BAD_START],
                 status_seen[ST_BAD_TIMING], status_seen[ST_OVERFLOW]);
        if (error_count == 0 && frame_reports_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: nec_ir_edge_decoder_top.f
+incdir+design
design/nird_pkg.sv
design/nird_fifo.sv
design/nird_front.sv
design/nird_back.sv
design/nec_ir_edge_decoder_top.sv
dv/nec_ir_edge_decoder_top_tb.sv
